### src/rva_pkg.sv
`timescale 1ns / 1ps
package rva_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 17;
  localparam int unsigned SumW    = 33;
  localparam int unsigned SqW     = 48;
  localparam int unsigned MagW    = 32;
  localparam int unsigned NumW    = 62;
  localparam int unsigned DenW    = 32;
  localparam int unsigned VarW    = 32;
  localparam int unsigned UsedW   = 16;
  localparam int unsigned HalfW   = 24;
  localparam int unsigned OutW    = 56;

  localparam logic [CountW-1:0] MaxItems = CountW'(65535);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_SINGLE   = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;     // an input transaction completes this cycle
    logic mul0;      // first partial product, square of the sum, divisor
    logic mul1;      // second partial product and n*Q
    logic sub;       // numerator n*Q - S*S
    logic div_init;  // saturation check and divider load
    logic div_step;  // one quotient bit
    logic finish;    // load the result and clear the accumulators
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic special;   // the set ends without a division
  } dp_status_t;

endpackage

### src/rva_ctrl.sv
`timescale 1ns / 1ps
module rva_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_valid_i,
  input  logic              s_last_i,
  output logic              s_ready_o,
  output logic              m_valid_o,
  input  logic              m_ready_i,
  input  rva_pkg::dp_status_t st_i,
  output rva_pkg::cmd_t     cmd_o
);
  import rva_pkg::*;

  typedef enum logic [2:0] {
    S_ACCUM, S_MUL0, S_MUL1, S_SUB, S_DINIT, S_DIV, S_FINISH
  } state_e;

  state_e     state_q;
  logic [4:0] step_q;
  logic       out_valid_q;
  logic       accept;
  logic       load_out;

  assign s_ready_o = (state_q == S_ACCUM);
  assign accept    = s_valid_i && s_ready_o;
  assign load_out  = (state_q == S_FINISH) && (!out_valid_q || m_ready_i);
  assign m_valid_o = out_valid_q;

  always_comb begin
    cmd_o          = '0;
    cmd_o.accum    = accept;
    cmd_o.mul0     = (state_q == S_MUL0);
    cmd_o.mul1     = (state_q == S_MUL1);
    cmd_o.sub      = (state_q == S_SUB);
    cmd_o.div_init = (state_q == S_DINIT);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.finish   = load_out;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACCUM;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_ACCUM: begin
          if (accept && s_last_i) begin
            state_q <= S_MUL0;
          end
        end
        S_MUL0: begin
          state_q <= st_i.special ? S_FINISH : S_MUL1;
        end
        S_MUL1: state_q <= S_SUB;
        S_SUB: state_q <= S_DINIT;
        S_DINIT: begin
          step_q  <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          step_q <= step_q + 5'd1;
          if (step_q == 5'd31) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (load_out) begin
            state_q <= S_ACCUM;
          end
        end
        default: state_q <= S_ACCUM;
      endcase
    end
  end

endmodule

### src/rva_dp.sv
`timescale 1ns / 1ps
module rva_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_data_i,
  input  logic signed [rva_pkg::SampleW-1:0] sample_i,
  input  logic                          present_i,
  input  rva_pkg::cmd_t                 cmd_i,
  output rva_pkg::dp_status_t           st_o,
  output logic [rva_pkg::VarW-1:0]      variance_o,
  output logic [rva_pkg::UsedW-1:0]     used_o,
  output rva_pkg::status_e              status_o
);
  import rva_pkg::*;

  logic                     mode_q;
  logic [CountW-1:0]        cnt_q;
  logic signed [SumW-1:0]   sum_q;
  logic [SqW-1:0]           sq_q;

  logic [UsedW+HalfW-1:0]   pl_q;
  logic [NumW-1:0]          nq_q;
  logic [2*MagW-1:0]        msq_q;
  logic [DenW-1:0]          den_q;
  logic [NumW-1:0]          num_q;
  logic                     sat_q;
  logic [DenW-1:0]          rem_q;
  logic [VarW-1:0]          quo_q;

  logic [VarW-1:0]          var_q;
  logic [UsedW-1:0]         used_q;
  status_e                  status_q;

  logic signed [2*SampleW-1:0] sq_prod;
  logic [UsedW-1:0]         n16;
  logic [SumW-1:0]          sum_abs;
  logic [MagW-1:0]          mag;
  logic [UsedW+HalfW-1:0]   ph;
  logic [2*MagW-1:0]        nq_full;
  logic [DenW:0]            trial;
  logic                     take;
  status_e                  status_now;

  assign sq_prod = sample_i * sample_i;
  assign n16     = cnt_q[UsedW-1:0];
  assign sum_abs = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign mag     = sum_abs[MagW-1:0];
  assign ph      = n16 * sq_q[SqW-1:HalfW];
  assign nq_full = (2*MagW)'(pl_q) + ((2*MagW)'(ph) << HalfW);
  assign trial   = {rem_q, quo_q[VarW-1]};
  assign take    = (trial >= {1'b0, den_q});

  always_comb begin
    priority if (cnt_q > MaxItems) begin
      status_now = ST_OVERFLOW;
    end else if (cnt_q == '0) begin
      status_now = ST_EMPTY;
    end else if (cnt_q == CountW'(1) && mode_q) begin
      status_now = ST_SINGLE;
    end else begin
      status_now = ST_OK;
    end
  end

  assign st_o.special = (status_now != ST_OK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      cnt_q  <= '0;
      sum_q  <= '0;
      sq_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      if (cmd_i.finish) begin
        cnt_q <= '0;
        sum_q <= '0;
        sq_q  <= '0;
      end else if (cmd_i.accum && present_i) begin
        if (cnt_q >= MaxItems) begin
          cnt_q <= MaxItems + CountW'(1);
        end else begin
          cnt_q <= cnt_q + CountW'(1);
          sum_q <= sum_q + SumW'(sample_i);
          sq_q  <= sq_q + SqW'(unsigned'(sq_prod));
        end
      end
    end
  end

  // Arithmetic for the final result; no reset needed on payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul0) begin
      pl_q  <= n16 * sq_q[HalfW-1:0];
      msq_q <= mag * mag;
      den_q <= mode_q ? DenW'(n16) * DenW'(n16 - UsedW'(1)) : DenW'(n16) * DenW'(n16);
    end
    if (cmd_i.mul1) begin
      nq_q <= nq_full[NumW-1:0];
    end
    if (cmd_i.sub) begin
      num_q <= nq_q - msq_q[NumW-1:0];
    end
    if (cmd_i.div_init) begin
      sat_q <= (DenW'(num_q[NumW-1:VarW]) >= den_q);
      rem_q <= DenW'(num_q[NumW-1:VarW]);
      quo_q <= num_q[VarW-1:0];
    end else if (cmd_i.div_step) begin
      rem_q <= take ? DenW'(trial - {1'b0, den_q}) : trial[DenW-1:0];
      quo_q <= {quo_q[VarW-2:0], take};
    end
    if (cmd_i.finish) begin
      status_q <= status_now;
      used_q   <= (cnt_q > CountW'(65535)) ? '1 : cnt_q[UsedW-1:0];
      if (status_now != ST_OK) begin
        var_q <= '0;
      end else if (sat_q) begin
        var_q <= '1;
      end else begin
        var_q <= quo_q;
      end
    end
  end

  assign variance_o = var_q;
  assign used_o     = used_q;
  assign status_o   = status_q;

endmodule

### src/running_variance_accumulator.sv
`timescale 1ns / 1ps
// Throughput: one sample transaction per cycle while a set is accumulating.
// After the transaction marked last, a set that needs a division passes through
// three arithmetic steps, a divider load, 32 divider steps and the result load;
// empty, single-sample and overflowed sets go from the first arithmetic step to
// the result load, which waits while an earlier result is unaccepted. Input stalls meanwhile.
// Reset (rst_ni low, asynchronous) clears the accumulators, the mode.
module running_variance_accumulator (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write channel: bit 0 selects sample variance (1) or
  // population variance (0).
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  // Sample stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample, signed Q8.8
  input  logic        s_axis_tuser,   // [0] present
  input  logic        s_axis_tlast,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata    // [31:0] variance, [47:32] used_count,
                                      // [49:48] status, [55:50] zero
);
  import rva_pkg::*;

  // The datapath keeps the count, the sum and the sum of squares of present
  // samples. When the transaction marked last has been folded in, the
  // controller steps the datapath through n*Q (two 16x24 partial products),
  // S*S, the divisor and a restoring divider that produces one quotient bit
  // per cycle. A quotient that would exceed 32 bits is caught before the
  // divider runs and saturates the variance.
  cmd_t       cmd;
  dp_status_t dp_st;
  logic [VarW-1:0]  variance;
  logic [UsedW-1:0] used;
  status_e          status;

  assign cfg_ready_o = 1'b1;

  rva_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_last_i  (s_axis_tlast),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .st_i      (dp_st),
    .cmd_o     (cmd)
  );

  rva_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata),
    .present_i   (s_axis_tuser),
    .cmd_i       (cmd),
    .st_o        (dp_st),
    .variance_o  (variance),
    .used_o      (used),
    .status_o    (status)
  );

  assign m_axis_tdata = {6'd0, status, used, variance};

  // The controller must stop taking samples once a set has ended.
  a_stall_after_last : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready
  ) else $error("sample accepted while a result is being computed");

  // Any status other than ok carries a zero variance.
  a_special_zero : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[49:48] != ST_OK)) |-> (m_axis_tdata[31:0] == '0)
  ) else $error("nonzero variance with a non-ok status");

  // An empty set reports a used count of zero.
  a_empty_count : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[49:48] == ST_EMPTY)) |-> (m_axis_tdata[47:32] == '0)
  ) else $error("empty set reports a nonzero count");

endmodule
